// ----- rtl/tpd_pkg.sv -----
// Shared types and constants for the touch pad press detector.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package tpd_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int CAL_SUM_W     = 20;
  localparam int CAL_IDX_W     = 4;
  localparam int SCAN_CNT_W    = 8;
  localparam int LOCKOUT_W     = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CAL_IDX_W-1:0]  CAL_SAMPLES   = 4'd10;
  localparam int                    CAL_SHIFT     = 3;
  localparam logic [LOCKOUT_W-1:0]  LOCKOUT_LOAD  = 2'd3;
  localparam logic [SCAN_CNT_W-1:0] SCAN_COUNT_RESET = 8'd1;
  localparam logic [SAMPLE_W-1:0]   MARGIN_RESET  = 16'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN          = 2'd2;

  localparam logic OP_CAL  = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  localparam logic KIND_BASELINE = 1'b0;
  localparam logic KIND_VERDICT  = 1'b1;

  typedef struct packed {
    logic [SCAN_CNT_W-1:0] scan_count;
    logic                  continuous_mode;
    logic [SAMPLE_W-1:0]   margin;
  } tpd_cfg_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] baseline;
  } tpd_cal_res_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] peak;
    logic                pressed;
  } tpd_scan_res_t;

endpackage

// ----- rtl/tpd_in_if.sv -----
// Input channel of the touch pad press detector: valid/ready plus one sample item.
// Depends on tpd_pkg for the field widths.
interface tpd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [tpd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

// ----- rtl/tpd_out_if.sv -----
// Result channel of the touch pad press detector: valid/ready plus one result item.
// Depends on tpd_pkg for the field widths.
interface tpd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [tpd_pkg::SAMPLE_W-1:0] baseline;
  logic [tpd_pkg::SAMPLE_W-1:0] peak;
  logic                         pressed;

  modport source (output valid, output kind, output baseline, output peak, output pressed,
                  input ready);
  modport sink   (input valid, input kind, input baseline, input peak, input pressed,
                  output ready);
endinterface

// ----- rtl/tpd_cal.sv -----
// Calibration accumulator: running sum, minimum and maximum over groups of ten
// samples, and the trimmed mean baseline register. Depends on tpd_pkg.
module tpd_cal (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [tpd_pkg::SAMPLE_W-1:0] sample,
  output logic [tpd_pkg::SAMPLE_W-1:0] baseline,
  output tpd_pkg::tpd_cal_res_t        res
);

  logic [tpd_pkg::CAL_IDX_W-1:0] cal_index_r, cal_index_nxt;
  logic [tpd_pkg::CAL_SUM_W-1:0] cal_sum_r, cal_sum_nxt;
  logic [tpd_pkg::SAMPLE_W-1:0]  cal_min_r, cal_min_nxt;
  logic [tpd_pkg::SAMPLE_W-1:0]  cal_max_r, cal_max_nxt;
  logic [tpd_pkg::SAMPLE_W-1:0]  baseline_r;
  logic [tpd_pkg::CAL_SUM_W-1:0] trimmed;
  logic                          group_done;

  always_comb begin
    cal_sum_nxt   = cal_sum_r + {{(tpd_pkg::CAL_SUM_W-tpd_pkg::SAMPLE_W){1'b0}}, sample};
    cal_min_nxt   = (sample < cal_min_r) ? sample : cal_min_r;
    cal_max_nxt   = (sample > cal_max_r) ? sample : cal_max_r;
    cal_index_nxt = cal_index_r + 1'b1;
    group_done    = (cal_index_nxt >= tpd_pkg::CAL_SAMPLES);
    // The sum always contains both extremes, so this is not negative once the group holds two or more samples.
    trimmed = cal_sum_nxt
            - {{(tpd_pkg::CAL_SUM_W-tpd_pkg::SAMPLE_W){1'b0}}, cal_min_nxt}
            - {{(tpd_pkg::CAL_SUM_W-tpd_pkg::SAMPLE_W){1'b0}}, cal_max_nxt};
    res.done     = take && group_done;
    res.baseline = trimmed[tpd_pkg::CAL_SHIFT +: tpd_pkg::SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_index_r <= '0;
      cal_sum_r   <= '0;
      cal_min_r   <= '1;
      cal_max_r   <= '0;
      baseline_r  <= '0;
    end else if (take) begin
      if (group_done) begin
        cal_index_r <= '0;
        cal_sum_r   <= '0;
        cal_min_r   <= '1;
        cal_max_r   <= '0;
        baseline_r  <= res.baseline;
      end else begin
        cal_index_r <= cal_index_nxt;
        cal_sum_r   <= cal_sum_nxt;
        cal_min_r   <= cal_min_nxt;
        cal_max_r   <= cal_max_nxt;
      end
    end
  end

  assign baseline = baseline_r;

endmodule

// ----- rtl/tpd_scan.sv -----
// Detection scan: peak tracking over scan_count samples, threshold compare and
// the lockout counter that suppresses repeated reports. Depends on tpd_pkg.
module tpd_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic [tpd_pkg::SAMPLE_W-1:0] sample,
  input  logic [tpd_pkg::SAMPLE_W-1:0] baseline,
  input  tpd_pkg::tpd_cfg_t            cfg,
  output tpd_pkg::tpd_scan_res_t       res
);

  logic [tpd_pkg::SCAN_CNT_W-1:0] scan_index_r;
  logic [tpd_pkg::SAMPLE_W-1:0]   scan_peak_r, scan_peak_nxt;
  logic [tpd_pkg::LOCKOUT_W-1:0]  lockout_r, lockout_nxt;
  logic [tpd_pkg::LOCKOUT_W-1:0]  lock_base, lock_hit;
  logic [tpd_pkg::SCAN_CNT_W:0]   taken, count;
  logic [tpd_pkg::SAMPLE_W:0]     threshold;
  logic                           scan_end, hit;

  always_comb begin
    scan_peak_nxt = (sample > scan_peak_r) ? sample : scan_peak_r;
    taken = {1'b0, scan_index_r} + 1'b1;
    // A scan count of zero behaves as one.
    count = (cfg.scan_count == '0) ? {{tpd_pkg::SCAN_CNT_W{1'b0}}, 1'b1}
                                   : {1'b0, cfg.scan_count};
    scan_end  = (taken >= count);
    threshold = {1'b0, baseline} + {1'b0, cfg.margin};
    hit       = ({1'b0, scan_peak_nxt} > threshold);
    lock_base = cfg.continuous_mode ? '0 : lockout_r;
    lock_hit  = hit ? tpd_pkg::LOCKOUT_LOAD : lock_base;
    lockout_nxt = (lock_hit != '0) ? lock_hit - 1'b1 : lock_hit;
    res.done    = take && scan_end;
    res.peak    = scan_peak_nxt;
    res.pressed = hit && (lock_base == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_index_r <= '0;
      scan_peak_r  <= '0;
      lockout_r    <= '0;
    end else if (take) begin
      if (scan_end) begin
        scan_index_r <= '0;
        scan_peak_r  <= '0;
        lockout_r    <= lockout_nxt;
      end else begin
        scan_index_r <= taken[tpd_pkg::SCAN_CNT_W-1:0];
        scan_peak_r  <= scan_peak_nxt;
      end
    end
  end

endmodule

// ----- rtl/touch_pad_press_detector_core.sv -----
// Top level of the touch pad press detector.
// Depends on tpd_pkg, tpd_in_if, tpd_out_if, tpd_cal and tpd_scan.
//
// Usage: each input item carries an op bit and a 16-bit charge-time sample.
// Calibration items (op 0) are gathered in groups of ten; the tenth one
// produces a baseline item (kind 0) holding the trimmed mean of the group.
// Detection items (op 1) are gathered in scans of scan_count samples; the
// last sample of a scan produces a verdict item (kind 1) with the scan peak
// and a pressed flag. All other input items produce no result.
// Configuration is written through cfg_we/cfg_idx/cfg_data while the block
// is idle; register 0 is scan_count, 1 is continuous_mode, 2 is margin.
// A result is registered: it appears on the output channel in the cycle after the
// input item that causes it is accepted. The block takes one item per cycle while
// the receiver does not stall, set by the single accept-to-result-register path.
// Reset (rst_n low, synchronous) clears all accumulators, the baseline,
// the lockout and the output valid, and restores the configuration defaults.
// When the receiver stalls, the result is held in the output register and
// in_ch.ready is low only while a result is pending and out_ch.ready is low;
// a new item is taken in the same cycle as the pending result is taken.
module touch_pad_press_detector_core (
  input  logic                           clk,
  input  logic                           rst_n,
  tpd_in_if.sink                         in_ch,
  tpd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  tpd_pkg::tpd_cfg_t      cfg_r;
  tpd_pkg::tpd_cal_res_t  cal_res;
  tpd_pkg::tpd_scan_res_t scan_res;

  logic                         accept;
  logic                         cal_take, scan_take;
  logic [tpd_pkg::SAMPLE_W-1:0] baseline;

  logic                         out_valid_r;
  logic                         out_kind_r;
  logic [tpd_pkg::SAMPLE_W-1:0] out_baseline_r;
  logic [tpd_pkg::SAMPLE_W-1:0] out_peak_r;
  logic                         out_pressed_r;

  // The block can take an item whenever the output register is free or is
  // being emptied in this very cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cal_take    = accept && (in_ch.op == tpd_pkg::OP_CAL);
  assign scan_take   = accept && (in_ch.op == tpd_pkg::OP_SCAN);

  // Configuration registers; an index outside the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_count      <= tpd_pkg::SCAN_COUNT_RESET;
      cfg_r.continuous_mode <= 1'b0;
      cfg_r.margin          <= tpd_pkg::MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        tpd_pkg::CFG_SCAN_COUNT:
          cfg_r.scan_count <= cfg_data[tpd_pkg::SCAN_CNT_W-1:0];
        tpd_pkg::CFG_CONTINUOUS_MODE:
          cfg_r.continuous_mode <= cfg_data[0];
        tpd_pkg::CFG_MARGIN:
          cfg_r.margin <= cfg_data[tpd_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  tpd_cal u_cal (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (cal_take),
    .sample   (in_ch.sample),
    .baseline (baseline),
    .res      (cal_res)
  );

  tpd_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (scan_take),
    .sample   (in_ch.sample),
    .baseline (baseline),
    .cfg      (cfg_r),
    .res      (scan_res)
  );

  // Output register. Only one of the two units can finish on a given item,
  // since each item goes to exactly one of them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cal_res.done || scan_res.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cal_res.done) begin
      out_kind_r     <= tpd_pkg::KIND_BASELINE;
      out_baseline_r <= cal_res.baseline;
      out_peak_r     <= '0;
      out_pressed_r  <= 1'b0;
    end else if (scan_res.done) begin
      out_kind_r     <= tpd_pkg::KIND_VERDICT;
      out_baseline_r <= baseline;
      out_peak_r     <= scan_res.peak;
      out_pressed_r  <= scan_res.pressed;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.baseline = out_baseline_r;
  assign out_ch.peak     = out_peak_r;
  assign out_ch.pressed  = out_pressed_r;

endmodule

// ----- tb/sv/tb_touch_pad_press_detector_core.sv -----
// Self-checking testbench for touch_pad_press_detector_core: random and directed sample items
// with an in-bench press predictor. Depends on tpd_pkg, tpd_in_if, tpd_out_if and the RTL.
`timescale 1ns / 1ps

module tb_touch_pad_press_detector_core;

  localparam int SAMPLE_MAX     = 65535;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int WATCHDOG_LIMIT = 4000;
  // The core answers in the cycle after the item that causes a result, so this
  // stretch of quiet is plenty for an item that causes none to retire.
  localparam int SETTLE_CYCLES  = 4;
  // Index 3 is decoded by nobody; a write there must leave every register alone.
  localparam logic [tpd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One result item as the predictor expects it.
  typedef struct packed {
    logic                         kind;
    logic [tpd_pkg::SAMPLE_W-1:0] baseline;
    logic [tpd_pkg::SAMPLE_W-1:0] peak;
    logic                         pressed;
  } pad_outcome_t;

  // Tracks the detector's calibration, scan and lockout state from the accepted
  // input items and keeps the results it predicts in arrival order.
  class pad_outcome_tracker;
    pad_outcome_t pending_outcomes[$];
    int           mismatches;

    logic [tpd_pkg::SCAN_CNT_W-1:0] scan_count;
    logic                           continuous_mode;
    logic [tpd_pkg::SAMPLE_W-1:0]   margin;

    logic [tpd_pkg::CAL_IDX_W-1:0]  cal_index;
    logic [tpd_pkg::CAL_SUM_W-1:0]  cal_sum;
    logic [tpd_pkg::SAMPLE_W-1:0]   cal_min;
    logic [tpd_pkg::SAMPLE_W-1:0]   cal_max;
    logic [tpd_pkg::SAMPLE_W-1:0]   baseline;
    logic [tpd_pkg::SCAN_CNT_W-1:0] scan_index;
    logic [tpd_pkg::SAMPLE_W-1:0]   scan_peak;
    logic [tpd_pkg::LOCKOUT_W-1:0]  lockout;

    function new();
      mismatches      = 0;
      scan_count      = tpd_pkg::SCAN_COUNT_RESET;
      continuous_mode = 1'b0;
      margin          = tpd_pkg::MARGIN_RESET;
      cal_index       = '0;
      cal_sum         = '0;
      cal_min         = '1;
      cal_max         = '0;
      baseline        = '0;
      scan_index      = '0;
      scan_peak       = '0;
      lockout         = '0;
    endfunction

    function void write_reg(logic [tpd_pkg::CFG_IDX_W-1:0] idx,
                            logic [tpd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tpd_pkg::CFG_SCAN_COUNT:      scan_count = data[tpd_pkg::SCAN_CNT_W-1:0];
        tpd_pkg::CFG_CONTINUOUS_MODE: continuous_mode = data[0];
        tpd_pkg::CFG_MARGIN:          margin = data;
        default: ;
      endcase
    endfunction

    function void take_sample(logic op, logic [tpd_pkg::SAMPLE_W-1:0] smp);
      logic [tpd_pkg::CAL_SUM_W-1:0] trimmed;
      logic [tpd_pkg::SAMPLE_W-1:0]  peak;
      logic                          pressed;
      int                            per_scan;
      int                            taken;
      if (op == tpd_pkg::OP_CAL) begin
        cal_sum = cal_sum + tpd_pkg::CAL_SUM_W'(smp);
        if (smp < cal_min) cal_min = smp;
        if (smp > cal_max) cal_max = smp;
        cal_index = cal_index + 1'b1;
        if (cal_index >= tpd_pkg::CAL_SAMPLES) begin
          // Trimmed mean: drop the extremes and divide the remaining eight.
          trimmed   = cal_sum - tpd_pkg::CAL_SUM_W'(cal_min) - tpd_pkg::CAL_SUM_W'(cal_max);
          baseline  = tpd_pkg::SAMPLE_W'(trimmed >> tpd_pkg::CAL_SHIFT);
          cal_index = '0;
          cal_sum   = '0;
          cal_min   = '1;
          cal_max   = '0;
          pending_outcomes.push_back('{kind: tpd_pkg::KIND_BASELINE, baseline: baseline,
                                       peak: '0, pressed: 1'b0});
        end
      end else begin
        per_scan = (scan_count == 0) ? 1 : int'(scan_count);
        if (smp > scan_peak) scan_peak = smp;
        taken = int'(scan_index) + 1;
        if (taken < per_scan) begin
          scan_index = tpd_pkg::SCAN_CNT_W'(taken);
        end else begin
          peak       = scan_peak;
          pressed    = 1'b0;
          scan_index = '0;
          scan_peak  = '0;
          if (continuous_mode) lockout = '0;
          // The threshold is formed wide enough that it never wraps.
          if (int'(peak) > int'(baseline) + int'(margin)) begin
            if (lockout == 0) pressed = 1'b1;
            lockout = tpd_pkg::LOCKOUT_LOAD;
          end
          if (lockout != 0) lockout = lockout - 1'b1;
          pending_outcomes.push_back('{kind: tpd_pkg::KIND_VERDICT, baseline: baseline,
                                       peak: peak, pressed: pressed});
        end
      end
    endfunction

    function void match_outcome(pad_outcome_t got);
      pad_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d baseline %0d peak %0d pressed %0d",
                 $time, got.kind, got.baseline, got.peak, got.pressed);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: result mismatch, expected kind %0d baseline %0d peak %0d pressed %0d",
                   $time, want.kind, want.baseline, want.peak, want.pressed);
          $display("%0t:                  actual kind %0d baseline %0d peak %0d pressed %0d",
                   $time, got.kind, got.baseline, got.peak, got.pressed);
        end
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [tpd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tpd_pkg::CFG_DATA_W-1:0] cfg_data;

  tpd_in_if  in_ch ();
  tpd_out_if out_ch ();

  touch_pad_press_detector_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  pad_outcome_tracker tracker;

  int idle_cycles = 0;
  int sent_items  = 0;
  int burst_left  = 0;
  // Phases switch the sender gaps and the receiver stalls off now and then so
  // that some stretches run at full rate.
  bit gaps_on     = 1'b1;
  bit stalls_on   = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything on the two channels is observed here at the rising edge, before
  // the core's registers move. The result is checked before the input item of
  // the same edge is noted, because that item's result can only come later.
  always @(posedge clk) begin : observe
    pad_outcome_t got;
    if (rst_n === 1'b1) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind     = out_ch.kind;
        got.baseline = out_ch.baseline;
        got.peak     = out_ch.peak;
        got.pressed  = out_ch.pressed;
        tracker.match_outcome(got);
      end
      if (in_ch.valid && in_ch.ready) tracker.take_sample(in_ch.op, in_ch.sample);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // A hung handshake on either side shows up as a long stretch with no item
  // moving at all.
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // The receiver alternates runs of ready cycles with stalls; most stalls are
  // short, a few are long enough to back up the input side.
  initial begin : receiver
    int run_left;
    int stall_left;
    out_ch.ready = 1'b0;
    run_left     = 0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 12);
          if (stalls_on) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                                     : $urandom_range(0, 4);
          end
        end
        out_ch.ready = 1'b1;
        run_left--;
      end
    end
  end

  function automatic logic [tpd_pkg::SAMPLE_W-1:0] clamp16(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return '1;
    return tpd_pkg::SAMPLE_W'(v);
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, span));
  endfunction

  // Offers one item and returns once it has been accepted. Items go out in
  // bursts; between bursts the channel idles with garbage on the payload.
  task automatic send_item(input logic op, input logic [tpd_pkg::SAMPLE_W-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (gaps_on) gap = ($urandom_range(0, 7) == 0) ? jitter(7) + 5 : jitter(3);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid  = 1'b0;
        in_ch.op     = 1'($urandom_range(0, 1));
        in_ch.sample = tpd_pkg::SAMPLE_W'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.op     = op;
    in_ch.sample = smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  // Stops offering items, lets every predicted result drain and then gives
  // any item without a result time to retire.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes are only issued from settle points, so the predictor can
  // take the new value right away.
  task automatic write_reg(input logic [tpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we   = 1'b0;
    tracker.write_reg(idx, data);
  endtask

  // A full calibration group around one level, sometimes at the rails, with
  // the odd detection item slipped in between.
  task automatic cal_group();
    int base;
    int spread;
    case ($urandom_range(0, 9))
      0:       base = 0;
      1:       base = SAMPLE_MAX;
      2:       base = jitter(SAMPLE_MAX);
      default: base = jitter(4800) + 200;
    endcase
    spread = jitter(64);
    for (int i = 0; i < int'(tpd_pkg::CAL_SAMPLES); i++) begin
      send_item(tpd_pkg::OP_CAL, clamp16(base + jitter(2 * spread) - spread));
      if ($urandom_range(0, 15) == 0) begin
        send_item(tpd_pkg::OP_SCAN, clamp16(int'(tracker.baseline) + jitter(40) - 20));
      end
    end
  endtask

  // A run of whole scans in which the pad is either held or released. Held
  // scans peak just past the threshold, sometimes exactly on it or one above;
  // released scans stay at or under it. Back-to-back runs exercise the lockout.
  task automatic scan_episode();
    int  per_scan;
    int  scans;
    int  threshold;
    int  target;
    bit  touched;
    per_scan  = (tracker.scan_count == 0) ? 1 : int'(tracker.scan_count);
    scans     = (per_scan > 40) ? 1 : jitter(3) + 1;
    touched   = 1'($urandom_range(0, 1));
    threshold = int'(tracker.baseline) + int'(tracker.margin);
    if (touched) begin
      target = threshold + (($urandom_range(0, 3) == 0) ? jitter(1) : jitter(399) + 1);
    end else begin
      target = threshold - jitter(60);
    end
    repeat (scans * per_scan) begin
      send_item(tpd_pkg::OP_SCAN,
                clamp16(target - (($urandom_range(0, 1) == 0) ? 0 : jitter(40))));
    end
  endtask

  // A few items of any op with random or rail values; these break groups and
  // scans at arbitrary points.
  task automatic noise_burst();
    int                           k;
    logic [tpd_pkg::SAMPLE_W-1:0] v;
    k = jitter(4) + 1;
    repeat (k) begin
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = '1;
        default: v = tpd_pkg::SAMPLE_W'($urandom);
      endcase
      send_item(1'($urandom_range(0, 1)), v);
    end
  endtask

  initial begin : stimulus
    int                             phase;
    int                             phase_start;
    int                             random_start;
    int                             budget;
    int                             per_scan;
    int                             pick;
    bit                             paused;
    bit                             cont;
    logic [tpd_pkg::SCAN_CNT_W-1:0] sc;
    logic [tpd_pkg::SAMPLE_W-1:0]   mg;

    tracker      = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = tpd_pkg::CFG_SCAN_COUNT;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.op     = tpd_pkg::OP_CAL;
    in_ch.sample = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset configuration: one sample per scan, margin 100,
    // normal mode. The baseline is still zero, so detection works against a
    // threshold of 100. The first press reports, the held pad is suppressed,
    // two quiet scans run the lockout out, and the next press reports again.
    send_item(tpd_pkg::OP_SCAN, 16'd0);
    send_item(tpd_pkg::OP_SCAN, 16'hFFFF);
    send_item(tpd_pkg::OP_SCAN, 16'd200);
    send_item(tpd_pkg::OP_SCAN, 16'd0);
    send_item(tpd_pkg::OP_SCAN, 16'd0);
    send_item(tpd_pkg::OP_SCAN, 16'd150);

    // A calibration group with one zero and nine full-scale samples. Trimming
    // drops the zero and one full-scale sample, so the baseline comes out at
    // full scale. A detection item in the middle must not disturb the group.
    send_item(tpd_pkg::OP_CAL, 16'd0);
    repeat (4) send_item(tpd_pkg::OP_CAL, 16'hFFFF);
    send_item(tpd_pkg::OP_SCAN, 16'd300);
    repeat (5) send_item(tpd_pkg::OP_CAL, 16'hFFFF);

    // Full-scale peak against full-scale baseline plus margin: the threshold
    // must not wrap, so this is no press.
    send_item(tpd_pkg::OP_SCAN, 16'hFFFF);

    // Zero margin, continuous mode, two samples per scan: a peak equal to the
    // baseline is still no press.
    settle();
    write_reg(tpd_pkg::CFG_MARGIN, 16'd0);
    write_reg(tpd_pkg::CFG_CONTINUOUS_MODE, 16'd1);
    write_reg(tpd_pkg::CFG_SCAN_COUNT, 16'd2);
    send_item(tpd_pkg::OP_SCAN, 16'hFFFF);
    send_item(tpd_pkg::OP_SCAN, 16'hFFFF);

    // Random part. Each phase picks a configuration at a settle point, with
    // the extremes of every register visited in turn, and then runs mostly
    // well-formed calibration groups and scans with some noise mixed in.
    // Configuration changes leave partial groups and scans behind on purpose,
    // which also covers a scan count lowered below the samples already taken.
    phase        = 0;
    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      settle();
      case (phase % 6)
        0:       sc = tpd_pkg::SCAN_CNT_W'(jitter(3) + 1);
        1:       sc = 8'd255;
        2:       sc = 8'd0;
        3:       sc = 8'd1;
        default: sc = ($urandom_range(0, 3) == 0) ? tpd_pkg::SCAN_CNT_W'(jitter(31) + 9)
                                                  : tpd_pkg::SCAN_CNT_W'(jitter(6) + 2);
      endcase
      case (phase % 4)
        0:       mg = 16'd0;
        1:       mg = 16'hFFFF;
        2:       mg = tpd_pkg::SAMPLE_W'(jitter(399) + 1);
        default: mg = ($urandom_range(0, 3) == 0) ? tpd_pkg::SAMPLE_W'($urandom)
                                                  : tpd_pkg::SAMPLE_W'(jitter(180) + 20);
      endcase
      case (phase % 3)
        0:       cont = 1'b0;
        1:       cont = 1'b1;
        default: cont = 1'($urandom_range(0, 1));
      endcase
      // Upper data bits are don't-care for the narrow registers, so they get
      // random values.
      write_reg(tpd_pkg::CFG_SCAN_COUNT, {8'($urandom), sc});
      write_reg(tpd_pkg::CFG_CONTINUOUS_MODE, {15'($urandom), cont});
      write_reg(tpd_pkg::CFG_MARGIN, mg);
      if (phase % 6 == 2) write_reg(CFG_UNUSED, tpd_pkg::CFG_DATA_W'($urandom));

      gaps_on   = (phase % 4 != 2);
      stalls_on = (phase % 5 != 3);
      per_scan  = (sc == 0) ? 1 : int'(sc);
      budget    = (per_scan > 40) ? per_scan + 20 : 100;

      phase_start = sent_items;
      paused      = 1'b0;
      while (sent_items - phase_start < budget) begin
        // Every third phase, the sender holds off halfway through until the
        // core has delivered every result it owes.
        if (phase % 3 == 1 && !paused && sent_items - phase_start >= budget / 2) begin
          settle();
          paused = 1'b1;
        end
        pick = jitter(99);
        if (pick < 25) begin
          cal_group();
        end else if (pick < 85) begin
          scan_episode();
        end else begin
          noise_burst();
        end
      end
      phase++;
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- touch_pad_press_detector_core.f -----
rtl/tpd_pkg.sv
rtl/tpd_in_if.sv
rtl/tpd_out_if.sv
rtl/tpd_cal.sv
rtl/tpd_scan.sv
rtl/touch_pad_press_detector_core.sv
tb/sv/tb_touch_pad_press_detector_core.sv
